### sv/hccf_pkg.sv
package hccf_pkg;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [4:0] MAX_DIGITS_RESET = 5'd16;

  typedef enum logic [5:0] {
    PH_LINE     = 6'b000001,
    PH_PAYLOAD  = 6'b000010,
    PH_TRAIL_CR = 6'b000100,
    PH_TRAIL_LF = 6'b001000,
    PH_DONE     = 6'b010000,
    PH_SINK     = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LINE = 2'd1,
    ST_BAD_HEX  = 2'd2,
    ST_SIZE     = 2'd3
  } status_e;

  // frame control state carried between the register bank and the step logic
  typedef struct packed {
    phase_e  phase;
    logic    cr_pending;
    logic    hex_bad;
    status_e err;
  } ctl_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       payload_last;
    logic       frame_done;
    status_e    status;
  } result_t;

  // {digit ok, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

### sv/hccf_in_if.sv
interface hccf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_last;

  modport source (output valid, in_byte, frame_last, input ready);
  modport sink (input valid, in_byte, frame_last, output ready);
endinterface

### sv/hccf_out_if.sv
interface hccf_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic       payload_last;
  logic       frame_done;
  logic [1:0] status;

  modport source (output valid, payload_valid, payload_byte, payload_last, frame_done,
                  status, input ready);
  modport sink (input valid, payload_valid, payload_byte, payload_last, frame_done,
                status, output ready);
endinterface

### sv/http_chunk_frame_checker_core.sv
// Channel  | Dir | Carries
// in_i     | in  | in_byte, frame_last
// out_o    | out | payload_valid, payload_byte, payload_last, frame_done, status
// cfg      | in  | max_line_digits (cfg_we_i, cfg_wdata_i)
//
// One byte per clock sustained while out_o is ready (input register, result register).
// Frame state is updated by the step logic as a byte moves from input to result register.
// Reset returns the frame state to the length line and the limit to 16.
// A stall on out_o holds the result; in_i keeps taking bytes until the input register fills.
module http_chunk_frame_checker_core #(
  parameter int LENGTH_BITS     = 64,
  parameter int LINE_COUNT_BITS = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  hccf_in_if.sink    in_i,
  hccf_out_if.source out_o
);
  import hccf_pkg::*;

  logic [4:0]                 max_digits_q;
  logic                       s0_valid_q;
  logic [7:0]                 s0_byte_q;
  logic                       s0_last_q;
  logic                       out_valid_q;
  result_t                    res_q;
  result_t                    res_d;
  ctl_t                       ctl_q;
  ctl_t                       ctl_d;
  logic [LINE_COUNT_BITS-1:0] line_count_q;
  logic [LINE_COUNT_BITS-1:0] line_count_d;
  logic [LENGTH_BITS-1:0]     decl_q;
  logic [LENGTH_BITS-1:0]     decl_d;
  logic [LENGTH_BITS-1:0]     rem_q;
  logic [LENGTH_BITS-1:0]     rem_d;
  logic                       in_xfer;
  logic                       out_free;
  logic                       adv;

  assign out_free = !out_valid_q || out_o.ready;
  assign adv      = s0_valid_q && out_free;
  assign in_i.ready = !s0_valid_q || out_free;
  assign in_xfer  = in_i.valid && in_i.ready;

  hccf_step #(
    .LENGTH_BITS    (LENGTH_BITS),
    .LINE_COUNT_BITS(LINE_COUNT_BITS)
  ) u_step (
    .ctl_i        (ctl_q),
    .line_count_i (line_count_q),
    .decl_i       (decl_q),
    .rem_i        (rem_q),
    .max_digits_i (max_digits_q),
    .byte_i       (s0_byte_q),
    .frame_last_i (s0_last_q),
    .ctl_o        (ctl_d),
    .line_count_o (line_count_d),
    .decl_o       (decl_d),
    .rem_o        (rem_d),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_digits_q <= MAX_DIGITS_RESET;
    end else if (cfg_we_i) begin
      max_digits_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s0_valid_q <= 1'b1;
      end else if (adv) begin
        s0_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= s0_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s0_byte_q <= in_i.in_byte;
      s0_last_q <= in_i.frame_last;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q        <= '{phase: PH_LINE, cr_pending: 1'b0, hex_bad: 1'b0, err: ST_OK};
      line_count_q <= '0;
      decl_q       <= '0;
      rem_q        <= '0;
    end else if (adv) begin
      ctl_q        <= ctl_d;
      line_count_q <= line_count_d;
      decl_q       <= decl_d;
      rem_q        <= rem_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.payload_valid = res_q.payload_valid;
  assign out_o.payload_byte  = res_q.payload_byte;
  assign out_o.payload_last  = res_q.payload_last;
  assign out_o.frame_done    = res_q.frame_done;
  assign out_o.status        = res_q.status;

`ifndef SYNTH
  a_payload_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.phase == PH_PAYLOAD |-> rem_q != '0)
    else $error("payload phase with nothing remaining");

  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s0_last_q |=> ctl_q.phase == PH_LINE && line_count_q == '0 && decl_q == '0)
    else $error("frame state not cleared after final byte");

  a_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status != ST_OK |-> res_q.frame_done)
    else $error("status reported before frame end");
`endif

endmodule

### sv/hccf_step.sv
module hccf_step #(
  parameter int LENGTH_BITS     = 64,
  parameter int LINE_COUNT_BITS = 5
) (
  input  hccf_pkg::ctl_t             ctl_i,
  input  logic [LINE_COUNT_BITS-1:0] line_count_i,
  input  logic [LENGTH_BITS-1:0]     decl_i,
  input  logic [LENGTH_BITS-1:0]     rem_i,
  input  logic [4:0]                 max_digits_i,
  input  logic [7:0]                 byte_i,
  input  logic                       frame_last_i,
  output hccf_pkg::ctl_t             ctl_o,
  output logic [LINE_COUNT_BITS-1:0] line_count_o,
  output logic [LENGTH_BITS-1:0]     decl_o,
  output logic [LENGTH_BITS-1:0]     rem_o,
  output hccf_pkg::result_t          res_o
);
  import hccf_pkg::*;

  localparam int CW = (LINE_COUNT_BITS > 5) ? LINE_COUNT_BITS : 5;
  localparam logic [CW-1:0] CountMax = CW'((1 << LINE_COUNT_BITS) - 1);

  logic [CW-1:0]              lim;
  logic [LINE_COUNT_BITS-1:0] cnt_p1;
  logic                       cnt_full;
  logic                       cnt_p1_full;
  logic [4:0]                 hexv;
  logic                       hex_ok;
  logic [LENGTH_BITS-1:0]     rem_m1;

  assign lim         = (CW'(max_digits_i) > CountMax) ? CountMax : CW'(max_digits_i);
  assign cnt_p1      = line_count_i + LINE_COUNT_BITS'(1);
  assign cnt_full    = CW'(line_count_i) >= lim;
  assign cnt_p1_full = CW'(cnt_p1) >= lim;
  assign hexv        = hex_decode(byte_i);
  assign hex_ok      = hexv[4] && (decl_i[LENGTH_BITS-1 -: 4] == 4'd0);
  assign rem_m1      = rem_i - LENGTH_BITS'(1);

  always_comb begin
    ctl_o        = ctl_i;
    line_count_o = line_count_i;
    decl_o       = decl_i;
    rem_o        = rem_i;
    res_o        = '0;
    res_o.frame_done = frame_last_i;

    case (ctl_i.phase)
      PH_LINE: begin
        if (ctl_i.cr_pending && byte_i == CH_LF) begin
          ctl_o.cr_pending = 1'b0;
          if (line_count_i == '0) begin
            ctl_o.phase = PH_SINK;
            ctl_o.err   = ST_BAD_LINE;
          end else if (ctl_i.hex_bad) begin
            ctl_o.phase = PH_SINK;
            ctl_o.err   = ST_BAD_HEX;
          end else begin
            rem_o       = decl_i;
            ctl_o.phase = (decl_i != '0) ? PH_PAYLOAD : PH_TRAIL_CR;
          end
        end else if (ctl_i.cr_pending) begin
          // lone CR counts as a non-hex line character
          ctl_o.cr_pending = 1'b0;
          if (cnt_full) begin
            ctl_o.phase = PH_SINK;
            ctl_o.err   = ST_BAD_LINE;
          end else begin
            line_count_o  = cnt_p1;
            ctl_o.hex_bad = 1'b1;
            if (byte_i == CH_CR) begin
              ctl_o.cr_pending = 1'b1;
            end else if (cnt_p1_full) begin
              ctl_o.phase = PH_SINK;
              ctl_o.err   = ST_BAD_LINE;
            end else begin
              line_count_o = cnt_p1 + LINE_COUNT_BITS'(1);
            end
          end
        end else begin
          if (byte_i == CH_CR) begin
            ctl_o.cr_pending = 1'b1;
          end else if (cnt_full) begin
            ctl_o.phase = PH_SINK;
            ctl_o.err   = ST_BAD_LINE;
          end else begin
            line_count_o = cnt_p1;
            if (!ctl_i.hex_bad) begin
              if (hex_ok) begin
                decl_o = {decl_i[LENGTH_BITS-5:0], hexv[3:0]};
              end else begin
                ctl_o.hex_bad = 1'b1;
              end
            end
          end
        end
      end
      PH_PAYLOAD: begin
        res_o.payload_valid = 1'b1;
        res_o.payload_byte  = byte_i;
        rem_o               = rem_m1;
        if (rem_m1 == '0) begin
          res_o.payload_last = 1'b1;
          ctl_o.phase        = PH_TRAIL_CR;
        end
      end
      PH_TRAIL_CR: begin
        if (byte_i == CH_CR) begin
          ctl_o.phase = PH_TRAIL_LF;
        end else begin
          ctl_o.phase = PH_SINK;
          ctl_o.err   = ST_SIZE;
        end
      end
      PH_TRAIL_LF: begin
        if (byte_i == CH_LF) begin
          ctl_o.phase = PH_DONE;
        end else begin
          ctl_o.phase = PH_SINK;
          ctl_o.err   = ST_SIZE;
        end
      end
      PH_DONE: begin
        ctl_o.phase = PH_SINK;
        ctl_o.err   = ST_SIZE;
      end
      default: begin
      end
    endcase

    if (frame_last_i) begin
      if (ctl_o.err != ST_OK) begin
        res_o.status = ctl_o.err;
      end else if (ctl_o.phase == PH_DONE) begin
        res_o.status = ST_OK;
      end else if (ctl_o.phase == PH_LINE) begin
        res_o.status = ST_BAD_LINE;
      end else begin
        res_o.status = ST_SIZE;
      end
      ctl_o.phase      = PH_LINE;
      ctl_o.cr_pending = 1'b0;
      ctl_o.hex_bad    = 1'b0;
      ctl_o.err        = ST_OK;
      line_count_o     = '0;
      decl_o           = '0;
      rem_o            = '0;
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hccf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 200;
  localparam int N_DIRECTED  = 23;
  localparam int N_SETTINGS  = 7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    result_t    want;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [4:0] cfg_wdata_i;

  hccf_in_if  in_if ();
  hccf_out_if out_if ();

  http_chunk_frame_checker_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // frame decoder model state
  phase_e      ph;
  logic [4:0]  line_len;
  logic [63:0] len_acc;
  logic [63:0] bytes_left;
  logic        cr_seen;
  logic        bad_digit;
  status_e     err_code;
  logic [4:0]  digit_limit;

  result_t     pending_results[$];
  logic [7:0]  frame_bytes[$];
  int          line_chars;
  logic        no_gaps;

  int mismatches   = 0;
  int transfers_in = 0;
  int results_seen = 0;
  int frames_sent  = 0;
  int cycles       = 0;
  int status_seen[4];

  dir_row_t   directed_rows[N_DIRECTED];
  logic [4:0] limit_plan[N_SETTINGS];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    if (mismatches < 40) begin
      $display("ERROR %0t result %0d: %s got %0h expected %0h", $time, results_seen, what,
               got_v, want_v);
    end
    mismatches++;
  endtask

  task automatic clear_frame();
    ph         = PH_LINE;
    line_len   = '0;
    len_acc    = '0;
    bytes_left = '0;
    cr_seen    = 1'b0;
    bad_digit  = 1'b0;
    err_code   = ST_OK;
  endtask

  task automatic abort_frame(input status_e code);
    err_code = code;
    ph       = PH_SINK;
  endtask

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  task automatic take_line_char(input logic [7:0] c);
    int d;
    if (line_len >= digit_limit) begin
      abort_frame(ST_BAD_LINE);
      return;
    end
    line_len++;
    if (bad_digit) return;
    d = hex_digit(c);
    if (d < 0 || len_acc[63:60] != 4'd0) begin
      bad_digit = 1'b1;
      return;
    end
    len_acc = {len_acc[59:0], d[3:0]};
  endtask

  task automatic chunk_step(input logic [7:0] b, input logic last, output result_t r);
    r            = '0;
    r.frame_done = last;
    case (ph)
      PH_LINE: begin
        if (cr_seen && b == CH_LF) begin
          cr_seen = 1'b0;
          if (line_len == 0) begin
            abort_frame(ST_BAD_LINE);
          end else if (bad_digit) begin
            abort_frame(ST_BAD_HEX);
          end else begin
            bytes_left = len_acc;
            ph = (bytes_left != 0) ? PH_PAYLOAD : PH_TRAIL_CR;
          end
        end else begin
          if (cr_seen) begin
            cr_seen = 1'b0;
            take_line_char(CH_CR);
          end
          if (ph == PH_LINE) begin
            if (b == CH_CR) cr_seen = 1'b1;
            else take_line_char(b);
          end
        end
      end
      PH_PAYLOAD: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        bytes_left      = bytes_left - 64'd1;
        if (bytes_left == 0) begin
          r.payload_last = 1'b1;
          ph = PH_TRAIL_CR;
        end
      end
      PH_TRAIL_CR: begin
        if (b == CH_CR) ph = PH_TRAIL_LF;
        else abort_frame(ST_SIZE);
      end
      PH_TRAIL_LF: begin
        if (b == CH_LF) ph = PH_DONE;
        else abort_frame(ST_SIZE);
      end
      PH_DONE: begin
        abort_frame(ST_SIZE);
      end
      default: ;
    endcase
    if (last) begin
      if (err_code != ST_OK) r.status = err_code;
      else if (ph == PH_DONE) r.status = ST_OK;
      else if (ph == PH_LINE) r.status = ST_BAD_LINE;
      else r.status = ST_SIZE;
      clear_frame();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input result_t want);
    int      gap;
    result_t pred;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= b;
    in_if.frame_last <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    chunk_step(b, last, pred);
    pending_results.push_back(typed ? want : pred);
    transfers_in++;
    if (last) frames_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, '0);
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  task automatic push_line(input logic [63:0] n, input int zeros);
    logic [7:0] digs[$];
    do begin
      digs.push_front(hex_char(n[3:0]));
      n = n >> 4;
    end while (n != 0);
    repeat (zeros) digs.push_front(8'h30);
    foreach (digs[i]) frame_bytes.push_back(digs[i]);
    line_chars = digs.size();
    frame_bytes.push_back(CH_CR);
    frame_bytes.push_back(CH_LF);
  endtask

  task automatic build_good();
    int n;
    int r;
    frame_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 80) n = $urandom_range(0, 8);
    else if (r < 96) n = $urandom_range(9, 40);
    else n = $urandom_range(41, 200);
    push_line(n, $urandom_range(0, 2));
    repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
    frame_bytes.push_back(CH_CR);
    frame_bytes.push_back(CH_LF);
  endtask

  task automatic build_random_frame();
    int kind;
    int cut;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      build_good();
    end else if (kind < 68) begin
      build_good();
      cut = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end else if (kind < 75) begin
      build_good();
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 82) begin
      build_good();
      frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind < 87) begin
      // bare CR inside the length line
      build_good();
      frame_bytes.insert($urandom_range(0, line_chars), CH_CR);
    end else if (kind < 92) begin
      // more digits than the accumulator holds
      frame_bytes.delete();
      frame_bytes.push_back(hex_char(4'($urandom_range(1, 15))));
      repeat ($urandom_range(16, 19)) frame_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
      frame_bytes.push_back(CH_CR);
      frame_bytes.push_back(CH_LF);
      repeat ($urandom_range(0, 2)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 96) begin
      frame_bytes.delete();
      repeat (int'(digit_limit) + $urandom_range(1, 3)) frame_bytes.push_back(8'h30);
      frame_bytes.push_back(CH_CR);
      frame_bytes.push_back(CH_LF);
      frame_bytes.push_back(CH_CR);
      frame_bytes.push_back(CH_LF);
    end else begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic set_digit_limit(input logic [4:0] v);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    digit_limit = v;
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got.payload_valid = out_if.payload_valid;
    got.payload_byte  = out_if.payload_byte;
    got.payload_last  = out_if.payload_last;
    got.frame_done    = out_if.frame_done;
    got.status        = status_e'(out_if.status);
    results_seen++;
    if (got.frame_done === 1'b1) status_seen[got.status]++;
    if (pending_results.size() == 0) begin
      report_mismatch("transfer with nothing expected, byte", got.payload_byte, 0);
      return;
    end
    want = pending_results.pop_front();
    if (got.payload_valid !== want.payload_valid)
      report_mismatch("payload_valid", got.payload_valid, want.payload_valid);
    if (got.payload_byte !== want.payload_byte)
      report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
    if (got.payload_last !== want.payload_last)
      report_mismatch("payload_last", got.payload_last, want.payload_last);
    if (got.frame_done !== want.frame_done)
      report_mismatch("frame_done", got.frame_done, want.frame_done);
    if (got.status !== want.status)
      report_mismatch("status", got.status, want.status);
  endtask

  // result side
  initial begin
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(out_if.valid === 1'b1 && out_if.ready === 1'b1)) @(posedge clk_i);
      check_result();
      @(negedge clk_i);
    end
  end

  initial begin
    int phase_start;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_if.valid      = 1'b0;
    in_if.in_byte    = '0;
    in_if.frame_last = 1'b0;
    out_if.ready     = 1'b0;
    no_gaps          = 1'b0;
    rst_ni           = 1'b0;
    digit_limit      = MAX_DIGITS_RESET;
    foreach (status_seen[i]) status_seen[i] = 0;
    clear_frame();

    directed_rows = '{
      // zero length, byte after the trailer
      '{8'h30, 1'b0, 1'b0, '0},
      '{CH_CR, 1'b0, 1'b0, '0},
      '{CH_LF, 1'b0, 1'b0, '0},
      '{CH_CR, 1'b0, 1'b0, '0},
      '{CH_LF, 1'b0, 1'b0, '0},
      '{8'hAA, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, ST_SIZE}},
      // empty line
      '{CH_CR, 1'b0, 1'b0, '0},
      '{CH_LF, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, ST_BAD_LINE}},
      // non-hex digit
      '{8'h67, 1'b0, 1'b0, '0},
      '{CH_CR, 1'b0, 1'b0, '0},
      '{CH_LF, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, ST_BAD_HEX}},
      // two payload bytes at the extremes
      '{8'h32, 1'b0, 1'b0, '0},
      '{CH_CR, 1'b0, 1'b0, '0},
      '{CH_LF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, ST_OK}},
      '{8'hFF, 1'b0, 1'b1, '{1'b1, 8'hFF, 1'b1, 1'b0, ST_OK}},
      '{CH_CR, 1'b0, 1'b0, '0},
      '{CH_LF, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, ST_OK}},
      // ends inside the length line
      '{8'h46, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, ST_BAD_LINE}},
      // wrong trailer byte
      '{8'h30, 1'b0, 1'b0, '0},
      '{CH_CR, 1'b0, 1'b0, '0},
      '{CH_LF, 1'b0, 1'b0, '0},
      '{8'h58, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, ST_SIZE}}
    };
    limit_plan = '{5'd31, 5'd0, 5'd1, 5'd5, 5'd16, 5'($urandom_range(2, 30)), 5'd31};

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].want);
    end

    foreach (limit_plan[p]) begin
      set_digit_limit(limit_plan[p]);
      phase_start = transfers_in;
      while (transfers_in - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) no_gaps = ~no_gaps;
        build_random_frame();
        send_frame();
      end
    end

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), 0);

    $display("Sent %0d bytes in %0d frames over %0d limit settings, %0d results checked",
             transfers_in, frames_sent, N_SETTINGS + 1, results_seen);
    $display("Frame outcomes: ok %0d, bad line %0d, bad hex %0d, size %0d",
             status_seen[ST_OK], status_seen[ST_BAD_LINE], status_seen[ST_BAD_HEX],
             status_seen[ST_SIZE]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### http_chunk_frame_checker_core.f
sv/hccf_pkg.sv
sv/hccf_in_if.sv
sv/hccf_out_if.sv
sv/hccf_step.sv
sv/http_chunk_frame_checker_core.sv
verif/testbench.sv
